// File: hdl/urde_pkg.sv
// Shared types, constants and CRC-8 helpers of the register datagram engine.
`default_nettype none

package urde_pkg;

   localparam logic [7:0] SYNC_BYTE  = 8'h05;
   localparam logic [7:0] REPLY_ADDR = 8'hFF;
   localparam logic [7:0] CRC_POLY   = 8'h07;
   localparam logic [7:0] RX_LIMIT_RESET = 8'd20;
   localparam int         WINDOW_BYTES   = 8;
   localparam int         CRC_BITS       = 56;

   // Configuration register indexes (byte address bit 2).
   localparam logic REG_NODE_ADDRESS = 1'b0;
   localparam logic REG_RX_LIMIT     = 1'b1;

   // Result beat kinds.
   localparam logic KIND_TX      = 1'b0;
   localparam logic KIND_OUTCOME = 1'b1;

   typedef enum logic [1:0] {
      CMD_WRITE    = 2'd0,
      CMD_READ     = 2'd1,
      CMD_RX_BYTE  = 2'd2,
      CMD_END_WAIT = 2'd3
   } urde_cmd_type;

   // Frame request from the item register to the transmit sequencer.
   typedef struct packed {
      logic        active;
      logic        is_write;
      logic [6:0]  reg_address;
      logic [31:0] value;
   } urde_frame_req_type;

   // Commands from the item register to the receive search.
   typedef struct packed {
      logic       take;
      logic       arm;
      logic [6:0] arm_register;
      logic [7:0] data;
   } urde_rx_cmd_type;

   typedef struct packed {
      logic        found;
      logic [31:0] value;
   } urde_rx_status_type;

   // One byte through the CRC, data fed least significant bit first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] acc_in, input logic [7:0] data);
      logic [7:0] acc;
      logic       fb;
      acc = acc_in;
      for (int b = 0; b < 8; b++) begin
         fb  = acc[7] ^ data[b];
         acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return acc;
   endfunction

   // Contribution of each single message bit to the CRC of a 56-bit message.
   function automatic logic [CRC_BITS-1:0][7:0] crc_columns();
      logic [CRC_BITS-1:0][7:0] cols;
      logic [7:0] acc;
      logic       fb;
      for (int pos = 0; pos < CRC_BITS; pos++) begin
         acc = 8'h00;
         for (int k = 0; k < CRC_BITS; k++) begin
            fb  = acc[7] ^ (k == pos);
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
         end
         cols[pos] = acc;
      end
      return cols;
   endfunction

   localparam logic [CRC_BITS-1:0][7:0] CRC_COLUMNS = crc_columns();

   // CRC of a 56-bit message (bit k is the k-th bit fed) as a parity network.
   function automatic logic [7:0] crc8_message(input logic [CRC_BITS-1:0] msg);
      logic [7:0] acc;
      acc = 8'h00;
      for (int k = 0; k < CRC_BITS; k++) begin
         acc = acc ^ (msg[k] ? CRC_COLUMNS[k] : 8'h00);
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

// File: hdl/urde_frame_tx.sv
// Transmit sequencer: emits write and read-request frames one byte a beat.
`default_nettype none

module urde_frame_tx
   import urde_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire urde_frame_req_type frame_req,
   input  wire logic [7:0]         node_address,
   input  wire logic               advance,
   output logic [7:0]              tx_data,
   output logic                    tx_last
);

   logic [2:0] idx_ff, idx_in;
   logic [7:0] crc_ff, crc_in;

   always_comb begin
      case (idx_ff)
         3'd0: tx_data = SYNC_BYTE;
         3'd1: tx_data = node_address;
         3'd2: tx_data = {frame_req.is_write, frame_req.reg_address};
         3'd3: tx_data = frame_req.is_write ? frame_req.value[31:24] : crc_ff;
         3'd4: tx_data = frame_req.value[23:16];
         3'd5: tx_data = frame_req.value[15:8];
         3'd6: tx_data = frame_req.value[7:0];
         default: tx_data = crc_ff;
      endcase
      tx_last = frame_req.is_write ? (idx_ff == 3'd7) : (idx_ff == 3'd3);
   end

   always_comb begin
      idx_in = idx_ff;
      crc_in = crc_ff;
      if (advance && frame_req.active) begin
         if (tx_last) begin
            idx_in = 3'd0;
            crc_in = 8'h00;
         end else begin
            idx_in = idx_ff + 3'd1;
            crc_in = crc8_byte(crc_ff, tx_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
         crc_ff <= 8'h00;
      end else begin
         idx_ff <= idx_in;
         crc_ff <= crc_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/urde_rx_search.sv
// Receive search: byte window, byte count and reply capture.
`default_nettype none

module urde_rx_search
   import urde_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire urde_rx_cmd_type rx_cmd,
   input  wire logic [7:0]      rx_limit,
   output urde_rx_status_type   rx_status
);

   logic [63:0] window_ff, window_in;
   logic [7:0]  taken_ff, taken_in;
   logic [6:0]  expect_ff, expect_in;
   logic        found_ff, found_in;
   logic [31:0] value_ff, value_in;

   logic [63:0]         window_next;
   logic [CRC_BITS-1:0] msg;
   logic                match;

   // The oldest byte sits in the top of the window and is fed to the CRC first.
   always_comb begin
      window_next = {window_ff[55:0], rx_cmd.data};
      for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
         for (int b = 0; b < 8; b++) begin
            msg[8*i + b] = window_next[56 - 8*i + b];
         end
      end
      match = (window_next[63:56] == SYNC_BYTE) &&
              (window_next[55:48] == REPLY_ADDR) &&
              (window_next[46:40] == expect_ff) &&
              (crc8_message(msg) == window_next[7:0]);
   end

   always_comb begin
      window_in = window_ff;
      taken_in  = taken_ff;
      expect_in = expect_ff;
      found_in  = found_ff;
      value_in  = value_ff;
      if (rx_cmd.arm) begin
         window_in = 64'd0;
         taken_in  = 8'd0;
         expect_in = rx_cmd.arm_register;
         found_in  = 1'b0;
         value_in  = 32'd0;
      end else if (rx_cmd.take && (taken_ff < rx_limit)) begin
         window_in = window_next;
         taken_in  = taken_ff + 8'd1;
         if (!found_ff && (taken_ff >= 8'(WINDOW_BYTES - 1)) && match) begin
            found_in = 1'b1;
            value_in = window_next[39:8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= 64'd0;
         taken_ff  <= 8'd0;
         expect_ff <= 7'd0;
         found_ff  <= 1'b0;
         value_ff  <= 32'd0;
      end else begin
         window_ff <= window_in;
         taken_ff  <= taken_in;
         expect_ff <= expect_in;
         found_ff  <= found_in;
         value_ff  <= value_in;
      end
   end

   assign rx_status.found = found_ff;
   assign rx_status.value = value_ff;

endmodule

`default_nettype wire

// File: hdl/uart_register_datagram_engine.sv
// Top level of the register datagram engine: item register, result register, CSRs.
`default_nettype none

// Master side of a single-wire register datagram link with CRC-8 (polynomial
// 0x07, bits fed least significant first) protection. Each request beat carries
// a command in req_tuser: a write command produces the eight-byte write frame
// (sync, node address, register with bit 7 set, value most significant byte
// first, CRC) as eight result beats, a read command produces the four-byte read
// request and restarts the reply search, a received-byte command shifts one
// line byte into the search window and produces no result, and an end-of-wait
// command produces one outcome beat carrying the captured value and its
// validity. Frame bytes leave through a single result register at one byte a
// beat while the result channel is not stalled. A new request beat is taken
// in the same cycle that the previous item finishes; only a received-byte item
// can finish while a result waits on a stalled result channel. Reply capture
// happens in the cycle a byte is taken; the first window with sync, 0xFF, the
// requested register and a correct CRC wins, and at most rx_limit bytes are
// looked at after each read request. The node address and the receive limit
// are written through the CSR port at byte addresses 0 and 4; the user must
// write them only while the block is idle, which the block does not enforce.

module uart_register_datagram_engine
   import urde_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // reg_address[6:0], write_value[38:7], rx_byte[46:39]
   input  wire logic [1:0]  req_tuser,   // command[1:0]
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // tx_byte[7:0], read_value[39:8], read_ok[40]
   output logic             rsp_tuser,   // kind[0]
   output logic             rsp_tlast,
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // Configuration registers.
   logic [7:0] node_ff, limit_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff  <= 8'd0;
         limit_ff <= RX_LIMIT_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_RX_LIMIT) begin
            limit_ff <= csr_pwdata[7:0];
         end else begin
            node_ff <= csr_pwdata[7:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_RX_LIMIT) ? {24'd0, limit_ff} : {24'd0, node_ff};

   // Item register: holds the request beat being worked on.
   logic         cur_valid_ff, cur_valid_in;
   urde_cmd_type cur_cmd_ff;
   logic [6:0]   cur_reg_ff;
   logic [31:0]  cur_value_ff;
   logic [7:0]   cur_rxb_ff;

   logic req_accept, out_free, emit, done, is_end;

   urde_frame_req_type frame_req;
   urde_rx_cmd_type    rx_cmd;
   urde_rx_status_type rx_status;
   logic [7:0]         tx_data;
   logic               tx_last;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid || rsp_tready;
   assign is_end     = (cur_cmd_ff == CMD_END_WAIT);

   // Every command other than a received byte puts one beat out per cycle that
   // the result register can take it; an item is done after its final beat.
   assign emit = cur_valid_ff && out_free && (cur_cmd_ff != CMD_RX_BYTE);
   assign done = cur_valid_ff &&
                 ((cur_cmd_ff == CMD_RX_BYTE) || (emit && (is_end || tx_last)));
   assign req_tready = !cur_valid_ff || done;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      if (req_accept) begin
         cur_valid_in = 1'b1;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cur_cmd_ff   <= urde_cmd_type'(req_tuser);
         cur_reg_ff   <= req_tdata[6:0];
         cur_value_ff <= req_tdata[38:7];
         cur_rxb_ff   <= req_tdata[46:39];
      end
   end

   assign frame_req.active      = cur_valid_ff &&
                                  ((cur_cmd_ff == CMD_WRITE) || (cur_cmd_ff == CMD_READ));
   assign frame_req.is_write    = (cur_cmd_ff == CMD_WRITE);
   assign frame_req.reg_address = cur_reg_ff;
   assign frame_req.value       = cur_value_ff;

   urde_frame_tx u_frame_tx (
      .clock        (clock),
      .reset        (reset),
      .frame_req    (frame_req),
      .node_address (node_ff),
      .advance      (emit),
      .tx_data      (tx_data),
      .tx_last      (tx_last)
   );

   // The search restarts once the whole read request has gone out, so later
   // received bytes always see the new register.
   assign rx_cmd.take         = cur_valid_ff && (cur_cmd_ff == CMD_RX_BYTE);
   assign rx_cmd.arm          = done && (cur_cmd_ff == CMD_READ);
   assign rx_cmd.arm_register = cur_reg_ff;
   assign rx_cmd.data         = cur_rxb_ff;

   urde_rx_search u_rx_search (
      .clock     (clock),
      .reset     (reset),
      .rx_cmd    (rx_cmd),
      .rx_limit  (limit_ff),
      .rx_status (rx_status)
   );

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_last_ff, rsp_ok_ff;
   logic [7:0]  rsp_byte_ff;
   logic [31:0] rsp_value_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff  <= is_end ? KIND_OUTCOME : KIND_TX;
         rsp_byte_ff  <= is_end ? 8'd0 : tx_data;
         rsp_last_ff  <= is_end ? 1'b1 : tx_last;
         rsp_value_ff <= (is_end && rx_status.found) ? rx_status.value : 32'd0;
         rsp_ok_ff    <= is_end && rx_status.found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_ok_ff, rsp_value_ff, rsp_byte_ff};

endmodule

`default_nettype wire

// File: hdl/urde_checker.sv
// Port-level checker for the register datagram engine and its bind.
`default_nettype none

module urde_checker
   import urde_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   // No result beat is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat present after reset");

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // A read outcome is always a single-beat run without a frame byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_OUTCOME) |-> rsp_tlast && (rsp_tdata[7:0] == 8'd0))
      else $error("malformed read outcome beat");

   // Frame bytes never carry reply data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_TX) |-> (rsp_tdata[40:8] == 33'd0))
      else $error("transmit beat carries reply data");

   // A frame always opens with the sync byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=>
         !rsp_tvalid || (rsp_tuser == KIND_OUTCOME) || (rsp_tdata[7:0] == SYNC_BYTE))
      else $error("frame does not start with sync byte");

endmodule

bind uart_register_datagram_engine urde_checker u_urde_checker (.*);

`default_nettype wire
